// ===== src/varint_zigzag_decoder_unit_macros.svh =====
`ifndef VARINT_ZIGZAG_DECODER_UNIT_MACROS_SVH
`define VARINT_ZIGZAG_DECODER_UNIT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define VZD_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("varint decoder check failed");

// Consequence that must hold in the cycle after the antecedent.
`define VZD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("varint decoder check failed");

`endif

// ===== src/vzd_pkg.sv =====
package vzd_pkg;

   localparam int VALUE_WIDTH   = 64;
   localparam int COUNT_WIDTH   = 4;
   localparam int PAYLOAD_BITS  = 7;
   localparam int SHIFT_WIDTH   = 6;

   localparam logic [COUNT_WIDTH-1:0] MAX_BYTES = 4'd10;
   localparam logic [SHIFT_WIDTH-1:0] MAX_SHIFT = 6'd63;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_TRUNC = 2'd1;
   localparam logic [1:0] STATUS_OVF   = 2'd2;

   typedef struct packed {
      logic                   emit;
      logic [VALUE_WIDTH-1:0] value;
      logic [1:0]             status;
      logic [VALUE_WIDTH-1:0] next_acc;
      logic [COUNT_WIDTH-1:0] next_count;
   } step_result_type;

endpackage

// ===== src/vzd_step.sv =====
module vzd_step (
   input  logic [vzd_pkg::VALUE_WIDTH-1:0] acc,
   input  logic [vzd_pkg::COUNT_WIDTH-1:0] count,
   input  logic [7:0]                      data_byte,
   input  logic                            is_signed,
   input  logic                            last_in_packet,
   output vzd_pkg::step_result_type        result
);
   import vzd_pkg::*;

   logic [COUNT_WIDTH-1:0] count_eff;
   logic [VALUE_WIDTH-1:0] acc_eff;
   logic [6:0]             shift_full;
   logic [SHIFT_WIDTH-1:0] shamt;
   logic [VALUE_WIDTH-1:0] merged;
   logic [VALUE_WIDTH-1:0] zigzag;
   logic [COUNT_WIDTH-1:0] count_next;

   always_comb begin
      // A count past the last legal byte cannot occur, but restart cleanly if it does.
      if (count >= MAX_BYTES) begin
         count_eff = '0;
         acc_eff   = '0;
      end else begin
         count_eff = count;
         acc_eff   = acc;
      end
      shift_full = {3'd0, count_eff} * 7'(PAYLOAD_BITS);
      if (shift_full > {1'b0, MAX_SHIFT}) begin
         shamt = MAX_SHIFT;
      end else begin
         shamt = shift_full[SHIFT_WIDTH-1:0];
      end
      merged     = acc_eff | ({{(VALUE_WIDTH-PAYLOAD_BITS){1'b0}},
                               data_byte[PAYLOAD_BITS-1:0]} << shamt);
      zigzag     = {1'b0, merged[VALUE_WIDTH-1:1]} ^ {VALUE_WIDTH{merged[0]}};
      count_next = count_eff + 4'd1;

      result.emit       = 1'b1;
      result.value      = '0;
      result.status     = STATUS_OK;
      result.next_acc   = '0;
      result.next_count = '0;
      if (!data_byte[7]) begin
         result.value = is_signed ? zigzag : merged;
      end else if (count_next >= MAX_BYTES) begin
         result.status = STATUS_OVF;
      end else if (last_in_packet) begin
         result.status = STATUS_TRUNC;
      end else begin
         result.emit       = 1'b0;
         result.next_acc   = merged;
         result.next_count = count_next;
      end
   end

endmodule

// ===== src/varint_zigzag_decoder_unit.sv =====
// Streaming LEB128 decoder: takes one packet byte per transfer and gives one result
// (value and status) for each byte that ends a value, truncates it at packet end, or
// would need an eleventh byte. It accepts a byte every cycle; only a stalled result holds
// it. A byte passes from the input register through the accumulate step into the result
// register. That step feeds the accumulator back in the same cycle, so the next byte can
// follow at once.
// Error results carry a zero value; is_signed matters only on the closing byte.
`include "varint_zigzag_decoder_unit_macros.svh"

module varint_zigzag_decoder_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_is_signed,
   input  logic                            req_last_in_packet,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [vzd_pkg::VALUE_WIDTH-1:0] rsp_value,
   output logic [1:0]                      rsp_status
);
   import vzd_pkg::*;

   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_byte_ff;
   logic                   in_signed_ff;
   logic                   in_last_ff;
   logic [VALUE_WIDTH-1:0] acc_ff;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic                   out_valid_ff, out_valid_in;
   logic [VALUE_WIDTH-1:0] out_value_ff;
   logic [1:0]             out_status_ff;

   step_result_type step;
   logic            advance;
   logic            load_in;
   logic            out_free;

   vzd_step u_step (
      .acc            (acc_ff),
      .count          (count_ff),
      .data_byte      (in_byte_ff),
      .is_signed      (in_signed_ff),
      .last_in_packet (in_last_ff),
      .result         (step)
   );

   always_comb begin
      out_free  = !out_valid_ff || !rsp_stall;
      // A byte that yields no result never waits on the result side.
      advance   = in_valid_ff && (!step.emit || out_free);
      req_stall = in_valid_ff && !advance;
      load_in   = req_valid && !req_stall;

      if (load_in) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance && step.emit) begin
         out_valid_in = 1'b1;
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         acc_ff       <= '0;
         count_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            acc_ff   <= step.next_acc;
            count_ff <= step.next_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_in) begin
         in_byte_ff   <= req_data_byte;
         in_signed_ff <= req_is_signed;
         in_last_ff   <= req_last_in_packet;
      end
      if (advance && step.emit) begin
         out_value_ff  <= step.value;
         out_status_ff <= step.status;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_value  = out_value_ff;
   assign rsp_status = out_status_ff;

   `VZD_ASSERT_ALWAYS(a_count_range, clock, reset, count_ff < MAX_BYTES)
   `VZD_ASSERT_ALWAYS(a_error_zero, clock, reset,
      !(out_valid_ff && out_status_ff != STATUS_OK) || out_value_ff == '0)
   `VZD_ASSERT_NEXT(a_restart, clock, reset, advance && step.emit,
      acc_ff == '0 && count_ff == '0)
   `VZD_ASSERT_ALWAYS(a_stall_needs_item, clock, reset, !req_stall || in_valid_ff)

endmodule
